>>> hw/rtl/rdq_pkg.sv
// ----------------------------------------------------------------------------
// rdq_pkg: shared types and constants of the record deque
// Record layout, action codes, ring geometry and the command and status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package rdq_pkg;

	// Ring geometry
	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Stream widths
	localparam int S_DATA_W = 376;
	localparam int M_DATA_W = 376;
	localparam int S_USER_W = 3;
	localparam int M_USER_W = 1;
	localparam int POS_W    = 8;
	localparam int OCNT_W   = 5;

	// Action codes carried in the input tuser
	typedef enum logic [2:0] {
		ACT_PUSH_BACK  = 3'd0,
		ACT_PUSH_FRONT = 3'd1,
		ACT_POP_FRONT  = 3'd2,
		ACT_POP_BACK   = 3'd3,
		ACT_FIND_KEY   = 3'd4,
		ACT_READ_POS   = 3'd5
	} act_t;

	// One stored record, key in the lowest bits
	typedef struct packed {
		logic [31:0]        grade_three;
		logic [31:0]        grade_two;
		logic [31:0]        grade_one;
		logic [47:0]        name_d;
		logic [63:0]        name_c;
		logic [63:0]        name_b;
		logic [63:0]        name_a;
		logic signed [31:0] key;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	// Source of the read offset for the next cycle
	typedef enum logic [1:0] {
		OFF_HOLD,
		OFF_ZERO,
		OFF_INC,
		OFF_POS
	} off_sel_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SEARCH,
		ST_READ
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic     wr_en;
		logic     wr_front;
		logic     front_inc;
		logic     front_dec;
		logic     cnt_inc;
		logic     cnt_dec;
		off_sel_t off_sel;
		logic     res_ld;
		logic     res_ok;
		logic     res_rec;
	} rdq_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		act_t action;
		logic full;
		logic empty;
		logic pos_ok;
		logic key_match;
		logic search_last;
		logic out_free;
	} rdq_stat_t;

endpackage

>>> hw/rtl/rdq_datapath.sv
// ----------------------------------------------------------------------------
// rdq_datapath: record storage, ring pointers and result register
// Holds the captured input word, the record memory with its registered read
// port, the front pointer, the entry count, the search offset and the output
// register with its valid flag.
// ----------------------------------------------------------------------------
module rdq_datapath (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_ld,
	input  rdq_pkg::act_t            in_action,
	input  rdq_pkg::rec_t            in_rec,
	input  logic [rdq_pkg::POS_W-1:0] in_pos,
	input  rdq_pkg::rdq_cmd_t        cmd,
	output rdq_pkg::rdq_stat_t       stat,
	input  logic                     m_ready,
	output logic                     out_valid,
	output logic                     out_ok,
	output rdq_pkg::rec_t            out_rec,
	output logic [rdq_pkg::OCNT_W-1:0] out_count
);
	import rdq_pkg::*;

	localparam logic [IDX_W:0]   CAP_SUM  = (IDX_W + 1)'(CAPACITY);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
	localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);

	act_t             action_q;
	rec_t             rec_q;
	logic [POS_W-1:0] pos_q;
	logic [IDX_W-1:0] front_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] off_q;
	rec_t             rdata_q;
	rec_t             mem [CAPACITY];
	logic             out_valid_q;
	logic             out_ok_q;
	rec_t             out_rec_q;
	logic [OCNT_W-1:0] out_count_q;

	logic [IDX_W-1:0] off_d;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] wr_addr;
	logic [IDX_W-1:0] front_dec;
	logic [IDX_W-1:0] front_inc;
	logic [IDX_W-1:0] front_d;
	logic [CNT_W-1:0] count_d;
	logic [IDX_W:0]   rd_sum;
	logic [IDX_W:0]   wb_sum;
	logic [IDX_W-1:0] rd_slot;
	logic [IDX_W-1:0] wb_slot;
	logic [POS_W-1:0] pos_m1;
	logic [IDX_W+POS_W-1:0] pos_m1_ext;
	logic [CNT_W+POS_W-1:0] pos_ext;
	logic [CNT_W+POS_W-1:0] cnt_pos_ext;
	logic [IDX_W+CNT_W-1:0] off_next_ext;
	logic [IDX_W+CNT_W-1:0] cnt_off_ext;
	logic [CNT_W+OCNT_W-1:0] cnt_out_ext;

	// Capture the accepted input word
	always_ff @(posedge clk) begin
		if (in_ld) begin
			action_q <= in_action;
			rec_q    <= in_rec;
			pos_q    <= in_pos;
		end
	end

	// Offset of the entry read in this cycle, relative to the front
	assign pos_m1     = pos_q - 1'b1;
	assign pos_m1_ext = {{IDX_W{1'b0}}, pos_m1};
	always_comb begin
		case (cmd.off_sel)
			OFF_ZERO: off_d = '0;
			OFF_INC:  off_d = off_q + 1'b1;
			OFF_POS:  off_d = pos_m1_ext[IDX_W-1:0];
			default:  off_d = off_q;
		endcase
	end

	// Ring slot arithmetic: both operands stay below the capacity
	assign rd_sum  = {1'b0, front_q} + {1'b0, off_d};
	assign rd_slot = (rd_sum >= CAP_SUM) ? IDX_W'(rd_sum - CAP_SUM) : rd_sum[IDX_W-1:0];
	assign rd_addr = rd_slot;

	assign wb_sum  = {1'b0, front_q} + {1'b0, IDX_W'(count_q)};
	assign wb_slot = (wb_sum >= CAP_SUM) ? IDX_W'(wb_sum - CAP_SUM) : wb_sum[IDX_W-1:0];

	assign front_dec = (front_q == '0) ? LAST_IDX : front_q - 1'b1;
	assign front_inc = (front_q == LAST_IDX) ? '0 : front_q + 1'b1;
	assign wr_addr   = cmd.wr_front ? front_dec : wb_slot;

	// Next front pointer and count
	always_comb begin
		front_d = front_q;
		if (cmd.front_dec) begin
			front_d = front_dec;
		end else if (cmd.front_inc) begin
			front_d = front_inc;
		end
		count_d = count_q;
		if (cmd.cnt_inc) begin
			count_d = count_q + 1'b1;
		end else if (cmd.cnt_dec) begin
			count_d = count_q - 1'b1;
		end
	end

	// Ring control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
			off_q   <= '0;
		end else begin
			front_q <= front_d;
			count_q <= count_d;
			off_q   <= off_d;
		end
	end

	// Record memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= rec_q;
		end
		rdata_q <= mem[rd_addr];
	end

	// Status toward the controller
	assign pos_ext      = {{CNT_W{1'b0}}, pos_q};
	assign cnt_pos_ext  = {{POS_W{1'b0}}, count_q};
	assign off_next_ext = {{CNT_W{1'b0}}, off_q} + 1'b1;
	assign cnt_off_ext  = {{IDX_W{1'b0}}, count_q};

	assign stat.action      = action_q;
	assign stat.full        = (count_q == CAP_CNT);
	assign stat.empty       = (count_q == '0);
	assign stat.pos_ok      = (pos_q != '0) && (pos_ext <= cnt_pos_ext);
	assign stat.key_match   = (rdata_q.key == rec_q.key);
	assign stat.search_last = (off_next_ext >= cnt_off_ext);
	assign stat.out_free    = !out_valid_q || m_ready;

	// Result register
	assign cnt_out_ext = {{OCNT_W{1'b0}}, count_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_ld) begin
			out_valid_q <= 1'b1;
		end else if (m_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_ld) begin
			out_ok_q    <= cmd.res_ok;
			out_rec_q   <= cmd.res_rec ? rdata_q : '0;
			out_count_q <= cnt_out_ext[OCNT_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_ok    = out_ok_q;
	assign out_rec   = out_rec_q;
	assign out_count = out_count_q;

endmodule

>>> hw/rtl/rdq_ctrl.sv
// ----------------------------------------------------------------------------
// rdq_ctrl: action sequencer of the record deque
// Takes one input word at a time, decides the action against the datapath
// status, walks the ring for a key search and loads the result register.
// ----------------------------------------------------------------------------
module rdq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rdq_pkg::rdq_stat_t stat,
	output rdq_pkg::rdq_cmd_t  cmd
);
	import rdq_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.off_sel = OFF_HOLD;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (stat.action)
					ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
						if (stat.out_free) begin
							cmd.res_ld = 1'b1;
							state_d    = ST_IDLE;
							if (!stat.full) begin
								cmd.wr_en     = 1'b1;
								cmd.wr_front  = (stat.action == ACT_PUSH_FRONT);
								cmd.front_dec = (stat.action == ACT_PUSH_FRONT);
								cmd.cnt_inc   = 1'b1;
								cmd.res_ok    = 1'b1;
							end
						end
					end
					ACT_POP_FRONT, ACT_POP_BACK: begin
						if (stat.out_free) begin
							cmd.res_ld = 1'b1;
							state_d    = ST_IDLE;
							if (!stat.empty) begin
								cmd.front_inc = (stat.action == ACT_POP_FRONT);
								cmd.cnt_dec   = 1'b1;
								cmd.res_ok    = 1'b1;
							end
						end
					end
					ACT_FIND_KEY: begin
						if (!stat.empty) begin
							cmd.off_sel = OFF_ZERO;
							state_d     = ST_SEARCH;
						end else if (stat.out_free) begin
							cmd.res_ld = 1'b1;
							state_d    = ST_IDLE;
						end
					end
					ACT_READ_POS: begin
						if (stat.pos_ok) begin
							cmd.off_sel = OFF_POS;
							state_d     = ST_READ;
						end else if (stat.out_free) begin
							cmd.res_ld = 1'b1;
							state_d    = ST_IDLE;
						end
					end
					default: begin
						// Unused action codes fail and change nothing.
						if (stat.out_free) begin
							cmd.res_ld = 1'b1;
							state_d    = ST_IDLE;
						end
					end
				endcase
			end
			ST_SEARCH: begin
				// The read data belongs to the current offset.
				if (stat.key_match) begin
					if (stat.out_free) begin
						cmd.res_ld  = 1'b1;
						cmd.res_ok  = 1'b1;
						cmd.res_rec = 1'b1;
						state_d     = ST_IDLE;
					end
				end else if (stat.search_last) begin
					if (stat.out_free) begin
						cmd.res_ld = 1'b1;
						state_d    = ST_IDLE;
					end
				end else begin
					cmd.off_sel = OFF_INC;
				end
			end
			ST_READ: begin
				if (stat.out_free) begin
					cmd.res_ld  = 1'b1;
					cmd.res_ok  = 1'b1;
					cmd.res_rec = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> hw/rtl/record_deque_with_search.sv
// ----------------------------------------------------------------------------
// record_deque_with_search: bounded double-ended queue of records
// Ring of CAPACITY records with push and pop at both ends, a key search
// from the front and a read by 1-based position.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one action word: the action code in s_tuser and
// the record or search key with the position in s_tdata. The master channel
// returns one result word per action: the ok flag in m_tuser, the record
// read (zero unless a search or position read succeeds) and the entry count.
// Actions run one at a time. A push or pop loads its result from the dispatch
// state once the input word is registered; a position read first reads the
// entry in dispatch and loads it from the read state. A key search reads one
// ring entry per cycle from the single memory read port, walking 1 to the
// count of entries (at most CAPACITY) before its result is loaded. s_tready
// rises again at the edge that loads the result, so a new word is taken only
// after the result of the last one is loaded.
// Reset clears the front pointer, the count and the output valid flag; the
// record memory keeps whatever it holds and is only read where pushed.
// A stalled receiver holds the result; the next action word is still taken
// and is worked up to the point where its result needs the output register.
// ----------------------------------------------------------------------------
module record_deque_with_search (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// s_tdata, low bit up: record_key, name_word_a, name_word_b, name_word_c,
	// name_word_d, grade_one, grade_two, grade_three, position
	input  logic [rdq_pkg::S_DATA_W-1:0]   s_tdata,
	// s_tuser: action
	input  logic [rdq_pkg::S_USER_W-1:0]   s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// m_tdata, low bit up: found_key, found_name_a, found_name_b,
	// found_name_c, found_name_d, found_grade_one, found_grade_two,
	// found_grade_three, entry_count, three zero bits
	output logic [rdq_pkg::M_DATA_W-1:0]   m_tdata,
	// m_tuser: ok
	output logic [rdq_pkg::M_USER_W-1:0]   m_tuser
);
	import rdq_pkg::*;

	rdq_cmd_t          cmd;
	rdq_stat_t         stat;
	logic              in_ld;
	rec_t              in_rec;
	logic              out_ok;
	rec_t              out_rec;
	logic [OCNT_W-1:0] out_count;

	assign in_ld  = s_tvalid && s_tready;
	assign in_rec = rec_t'(s_tdata[REC_W-1:0]);

	// Sequencer
	rdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Storage and result register
	rdq_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ld     (in_ld),
		.in_action (act_t'(s_tuser)),
		.in_rec    (in_rec),
		.in_pos    (s_tdata[REC_W+POS_W-1:REC_W]),
		.cmd       (cmd),
		.stat      (stat),
		.m_ready   (m_tready),
		.out_valid (m_tvalid),
		.out_ok    (out_ok),
		.out_rec   (out_rec),
		.out_count (out_count)
	);

	// Output packing
	assign m_tdata = {{(M_DATA_W - REC_W - OCNT_W){1'b0}}, out_count, out_rec};
	assign m_tuser = out_ok;

`ifndef SYNTHESIS
	// A result is loaded only while the output register can take it.
	a_res_ld_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_ld |-> stat.out_free)
		else $error("result loaded over a pending result");

	// Actions run one at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second word accepted while an action runs");

	// The ring is never written when full.
	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> !stat.full)
		else $error("record written into a full ring");

	// A count change always comes with a result.
	a_count_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.cnt_inc || cmd.cnt_dec) |-> (cmd.res_ld && cmd.res_ok))
		else $error("count changed without a successful result");
`endif

endmodule
